FILE: rtl/core/tmcw_pkg.sv
// shared constants, codes and types of the text mode console writer
`timescale 1ns / 1ps

package tmcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // port field widths
    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int MODE_W      = 2;
    localparam int CELL_ADDR_W = 11;
    localparam int POS_W       = 11;
    localparam int TOP_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam int CURSOR_ROW_RESET = (12 < ROWS) ? 12 : ROWS - 1;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [TOP_W-1:0]  TOP_RESET  = 5'd12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_TOP     = 1'd1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE   = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE       = 8'h20;
    localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'h7E;

    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0020;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CELL_W-1:0] t_cell;

    // sweep kinds: fill writes one value, scroll moves rows up and blanks the last
    typedef logic t_sweep_kind;
    localparam t_sweep_kind SWEEP_FILL   = 1'b0;
    localparam t_sweep_kind SWEEP_SCROLL = 1'b1;

    typedef struct packed {
        logic        start;
        t_sweep_kind kind;
        t_addr       first;
        t_cell       blank;
    } t_sweep_cmd;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        t_addr raddr;
    } t_mem_req;

endpackage

FILE: rtl/core/tmcw_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tmcw_sweep.sv
// address sequencer for screen fill, clear and scroll sweeps
`timescale 1ns / 1ps

module tmcw_sweep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmcw_pkg::t_sweep_cmd i_cmd,
    input  tmcw_pkg::t_cell      i_rdata,
    output tmcw_pkg::t_mem_req   o_req,
    output logic                 o_busy
);

    import tmcw_pkg::*;

    localparam t_addr LAST_ADDR = t_addr'(CELL_COUNT - 1);
    localparam t_addr COPY_END  = t_addr'((ROWS - 1) * COLUMNS);
    localparam t_addr ROW_STEP  = t_addr'(COLUMNS);

    logic        r_issue, n_issue;
    t_addr       r_addr, n_addr;
    t_sweep_kind r_kind, n_kind;
    t_cell       r_blank, n_blank;
    logic        r_wpend, n_wpend;
    t_addr       r_waddr, n_waddr;
    logic        r_wcopy, n_wcopy;
    logic        copying;

    // in scroll, cells above the last row take the cell one row further down
    assign copying = (r_kind == SWEEP_SCROLL) && (r_addr < COPY_END);

    always_comb begin
        n_issue = r_issue;
        n_addr  = r_addr;
        n_kind  = r_kind;
        n_blank = r_blank;
        // every write lands in the cycle after its address is issued
        n_wpend = r_issue;
        n_waddr = r_addr;
        n_wcopy = copying;
        if (r_issue) begin
            if (r_addr == LAST_ADDR) begin
                n_issue = 1'b0;
            end else begin
                n_addr = r_addr + 1'b1;
            end
        end else if (i_cmd.start) begin
            n_issue = 1'b1;
            n_addr  = i_cmd.first;
            n_kind  = i_cmd.kind;
            n_blank = i_cmd.blank;
        end
    end

    // reset starts a zero fill of the whole screen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b1;
            r_addr  <= '0;
            r_kind  <= SWEEP_FILL;
            r_blank <= RESET_CELL;
            r_wpend <= 1'b0;
            r_waddr <= '0;
            r_wcopy <= 1'b0;
        end else begin
            r_issue <= n_issue;
            r_addr  <= n_addr;
            r_kind  <= n_kind;
            r_blank <= n_blank;
            r_wpend <= n_wpend;
            r_waddr <= n_waddr;
            r_wcopy <= n_wcopy;
        end
    end

    assign o_req.we    = r_wpend;
    assign o_req.waddr = r_waddr;
    assign o_req.wdata = r_wcopy ? i_rdata : r_blank;
    assign o_req.raddr = copying ? (r_addr + ROW_STEP) : r_addr;
    assign o_busy      = r_issue | r_wpend;

    a_wpend_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> $past(r_issue))
        else $error("sweep write without an issued address");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_waddr <= LAST_ADDR))
        else $error("sweep write beyond the screen");

endmodule

FILE: rtl/core/text_mode_console_writer_top.sv
// top level of the text mode console writer
`timescale 1ns / 1ps

// text mode console writer: keeps a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) in one synchronous ram and a
// cursor in flip-flops, and returns one result per input transfer with the
// cursor position after the item and, for a cell read, the cell contents.
// after reset the block runs a clearing pass over the ram that writes every
// cell to zero, one cell a cycle; the input stall stays high during that
// pass, while configuration writes are taken at any time. a plain
// character, backspace, newline without scroll, ignored code, cell read or
// unused mode goes to the done state at the input transfer and puts its
// result in the output register once that register is free, and the input
// stall drops with that load. a scroll (newline or line wrap on the last
// row) or a region clear walks the ram from the scroll top row to the end,
// one cell a cycle through its single write port, before its result goes
// to the output register. one item is in flight at a time; the next input
// transfer is taken as soon as its result is in the output register, even
// while that result is still stalled
module text_mode_console_writer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmcw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tmcw_pkg::MODE_W-1:0]         i_mode,
    input  logic [tmcw_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [tmcw_pkg::CELL_ADDR_W-1:0]    i_cell_address,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tmcw_pkg::POS_W-1:0]          o_cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0]         o_cell_data
);

    import tmcw_pkg::*;

    // control states
    localparam logic [1:0] ST_BOOT  = 2'd0;  // reset clearing pass
    localparam logic [1:0] ST_IDLE  = 2'd1;  // waiting for an input transfer
    localparam logic [1:0] ST_SWEEP = 2'd2;  // scroll or clear running
    localparam logic [1:0] ST_DONE  = 2'd3;  // result ready for output register

    logic [1:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ATTR_W-1:0] r_attr;
    logic [TOP_W-1:0]  r_top;
    t_addr             r_rd_addr, n_rd_addr;
    logic              r_rd_ok, n_rd_ok;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_cursor_position;
    t_cell             r_cell_data;

    logic              in_xfer;
    logic              out_free;
    logic [ROW_W-1:0]  top_row;
    t_addr             top_addr;
    t_addr             cur_addr;
    t_cell             blank_cell;
    logic              addr_in_range;
    logic              next_line;

    logic              wr_we;
    t_addr             wr_addr;
    t_cell             wr_data;

    t_sweep_cmd        sweep_cmd;
    t_mem_req          sweep_req;
    t_mem_req          mem_req;
    logic              sweep_busy;
    t_cell             rdata;

    assign in_xfer  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // a scroll top at or beyond the last row acts as the last row
    assign top_row  = (int'(r_top) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(r_top);
    assign top_addr = t_addr'(int'(top_row) * COLUMNS);
    assign cur_addr = t_addr'(int'(r_row) * COLUMNS + int'(r_col));

    assign blank_cell    = {r_attr, CH_SPACE};
    assign addr_in_range = int'(i_cell_address) < CELL_COUNT;

    // item decode and cursor update, all done at the input transfer, and the control state flow
    always_comb begin
        n_state         = r_state;
        n_col           = r_col;
        n_row           = r_row;
        n_rd_addr       = r_rd_addr;
        n_rd_ok         = r_rd_ok;
        next_line       = 1'b0;
        wr_we           = 1'b0;
        wr_addr         = cur_addr;
        wr_data         = blank_cell;
        sweep_cmd.start = 1'b0;
        sweep_cmd.kind  = SWEEP_FILL;
        sweep_cmd.first = top_addr;
        sweep_cmd.blank = CLEAR_CELL;

        unique case (r_state)
            ST_BOOT: begin
                if (!sweep_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state   = ST_DONE;
                    n_rd_addr = addr_in_range ? t_addr'(i_cell_address) : '0;
                    n_rd_ok   = (i_mode == MODE_READ) && addr_in_range;
                    case (i_mode)
                        MODE_PUT: begin
                            if (i_char_code == CH_NEWLINE) begin
                                next_line = 1'b1;
                            end else if (i_char_code == CH_BACKSPACE) begin
                                // backspace at column zero leaves everything alone
                                if (r_col != '0) begin
                                    n_col   = r_col - 1'b1;
                                    wr_we   = 1'b1;
                                    wr_addr = cur_addr - 1'b1;
                                end
                            end else if ((i_char_code >= CH_FIRST_PRINT) &&
                                         (i_char_code <= CH_LAST_PRINT)) begin
                                wr_we   = 1'b1;
                                wr_data = {r_attr, i_char_code};
                                if (r_col == COL_W'(COLUMNS - 1)) begin
                                    next_line = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            n_col           = '0;
                            n_row           = top_row;
                            sweep_cmd.start = 1'b1;
                            sweep_cmd.kind  = SWEEP_FILL;
                            sweep_cmd.blank = CLEAR_CELL;
                            n_state         = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                    // newline or wrap: scroll only when leaving the last row
                    if (next_line) begin
                        n_col = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            sweep_cmd.start = 1'b1;
                            sweep_cmd.kind  = SWEEP_SCROLL;
                            sweep_cmd.blank = blank_cell;
                            n_state         = ST_SWEEP;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                if (!sweep_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ram port owner: the sweep while it runs, else the item logic; the read
    // address holds the requested cell so the read data stays put in done
    always_comb begin
        if (sweep_busy) begin
            mem_req = sweep_req;
        end else begin
            mem_req.we    = wr_we;
            mem_req.waddr = wr_addr;
            mem_req.wdata = wr_data;
            mem_req.raddr = (r_state == ST_IDLE) ?
                            (addr_in_range ? t_addr'(i_cell_address) : '0) : r_rd_addr;
        end
    end

    tmcw_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sweep_cmd),
        .i_rdata (rdata),
        .o_req   (sweep_req),
        .o_busy  (sweep_busy)
    );

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    // control state and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_BOOT;
            r_col     <= '0;
            r_row     <= ROW_W'(CURSOR_ROW_RESET);
            r_rd_addr <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_rd_addr <= n_rd_addr;
            r_rd_ok   <= n_rd_ok;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
            r_top  <= TOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEXT_ATTRIBUTE: r_attr <= i_cfg_data;
                CFG_SCROLL_TOP:     r_top  <= i_cfg_data[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register: loads the result in done once the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_cursor_position <= POS_W'(int'(r_row) * COLUMNS + int'(r_col));
            r_cell_data       <= r_rd_ok ? rdata : '0;
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_cursor_position;
    assign o_cell_data       = r_cell_data;

    a_idle_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !sweep_busy)
        else $error("item logic idle while a sweep owns the ram");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_W'(ROWS - 1)) && (r_col <= COL_W'(COLUMNS - 1)))
        else $error("cursor off screen");

    a_read_goes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_mode == MODE_READ)) |=> ((r_state == ST_DONE) && !sweep_busy))
        else $error("cell read did not complete in one cycle");

endmodule

FILE: tb/console_result_checker.sv
// result predictor and scoreboard for the text mode console writer
`timescale 1ns / 1ps

module console_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmcw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [tmcw_pkg::MODE_W-1:0]      i_mode,
    input  logic [tmcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tmcw_pkg::CELL_ADDR_W-1:0] i_cell_address,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [tmcw_pkg::POS_W-1:0]       i_cursor_position,
    input  logic [tmcw_pkg::CELL_W-1:0]      i_cell_data,
    output int                               o_mismatch_count,
    output int                               o_pending_results
);

    import tmcw_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CELL_W-1:0] cell_value;
    } t_console_result;

    logic [CELL_W-1:0] screen_image [CELL_COUNT];
    int unsigned       cursor_col;
    int unsigned       cursor_row;
    logic [ATTR_W-1:0] text_attr;
    logic [TOP_W-1:0]  scroll_top;
    t_console_result   expected_results [$];
    int                mismatch_total;
    int                result_index;

    // scroll top values past the last row act as the last row
    function automatic int unsigned region_top();
        return (scroll_top >= ROWS) ? ROWS - 1 : scroll_top;
    endfunction

    function automatic logic [CELL_W-1:0] attr_blank();
        return {text_attr, CH_SPACE};
    endfunction

    function automatic void scroll_region();
        for (int unsigned r = region_top(); r + 1 < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                screen_image[r * COLUMNS + c] = screen_image[(r + 1) * COLUMNS + c];
        for (int c = 0; c < COLUMNS; c++)
            screen_image[(ROWS - 1) * COLUMNS + c] = attr_blank();
    endfunction

    function automatic void advance_row();
        cursor_col = 0;
        if (cursor_row + 1 >= ROWS) begin
            scroll_region();
            cursor_row = ROWS - 1;
        end else begin
            cursor_row++;
        end
    endfunction

    function automatic void put_character(input logic [CHAR_W-1:0] ch);
        if (ch == CH_NEWLINE) begin
            advance_row();
        end else if (ch == CH_BACKSPACE) begin
            if (cursor_col > 0) begin
                cursor_col--;
                screen_image[cursor_row * COLUMNS + cursor_col] = attr_blank();
            end
        end else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
            screen_image[cursor_row * COLUMNS + cursor_col] = {text_attr, ch};
            cursor_col++;
            if (cursor_col >= COLUMNS)
                advance_row();
        end
    endfunction

    function automatic void clear_region();
        for (int unsigned i = region_top() * COLUMNS; i < CELL_COUNT; i++)
            screen_image[i] = CLEAR_CELL;
        cursor_col = 0;
        cursor_row = region_top();
    endfunction

    function automatic t_console_result predict_result(input logic [MODE_W-1:0] mode,
                                                       input logic [CHAR_W-1:0] ch,
                                                       input logic [CELL_ADDR_W-1:0] addr);
        t_console_result res;
        res.cell_value = '0;
        case (mode)
            MODE_PUT: begin
                put_character(ch);
            end
            MODE_READ: begin
                if (addr < CELL_COUNT)
                    res.cell_value = screen_image[addr];
            end
            MODE_CLEAR: begin
                clear_region();
            end
            default: ;
        endcase
        res.cursor = POS_W'(cursor_row * COLUMNS + cursor_col);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_console_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_image[i] = RESET_CELL;
            cursor_col     = 0;
            cursor_row     = CURSOR_ROW_RESET;
            text_attr      = ATTR_RESET;
            scroll_top     = TOP_RESET;
            mismatch_total = 0;
            result_index   = 0;
            expected_results.delete();
        end else begin
            // compare before predicting, a result never belongs to this edge's item
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT)
                        $display("result %0d unexpected: cursor_position %0d cell_data 0x%h",
                                 result_index, i_cursor_position, i_cell_data);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.cursor !== i_cursor_position ||
                        want.cell_value !== i_cell_data) begin
                        if (mismatch_total < REPORT_LIMIT)
                            $display({"result %0d wrong: cursor_position expected %0d got %0d,",
                                      " cell_data expected 0x%h got 0x%h"},
                                     result_index, want.cursor, i_cursor_position,
                                     want.cell_value, i_cell_data);
                        mismatch_total++;
                    end
                end
                result_index++;
            end
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_index == CFG_TEXT_ATTRIBUTE)
                    text_attr = i_cfg_data[ATTR_W-1:0];
                else if (i_cfg_index == CFG_SCROLL_TOP)
                    scroll_top = i_cfg_data[TOP_W-1:0];
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                expected_results.push_back(predict_result(i_mode, i_char_code, i_cell_address));
        end
        o_mismatch_count  <= mismatch_total;
        o_pending_results <= expected_results.size();
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for the text mode console writer
`timescale 1ns / 1ps

module testbench;
    import tmcw_pkg::*;

    // mode code the block treats as a no-op
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // slowest legal item is a full-screen scroll plus both idle draws,
    // taken a few times over, plus the clearing pass after reset
    localparam int SLOW_ITEM_CYCLES = ROWS * COLUMNS + 3 + 3 + 3;
    localparam int CYCLE_LIMIT      = 4 * (1800 * SLOW_ITEM_CYCLES + CELL_COUNT + 1);

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [MODE_W-1:0]      i_mode;
    logic [CHAR_W-1:0]      i_char_code;
    logic [CELL_ADDR_W-1:0] i_cell_address;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [POS_W-1:0]       o_cursor_position;
    logic [CELL_W-1:0]      o_cell_data;

    int mismatch_count;
    int pending_results;
    int cycles_elapsed = 0;

    // sender idles nowhere while this is set
    bit in_quiet = 1'b0;

    text_mode_console_writer_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data)
    );

    // watches both channels and the register port, predicts and compares
    console_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_cursor_position (o_cursor_position),
        .i_cell_data       (o_cell_data),
        .o_mismatch_count  (mismatch_count),
        .o_pending_results (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycles_elapsed <= cycles_elapsed + 1;
        if (cycles_elapsed >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one input transfer; an idle gap of random length may go first, none while in_quiet is
    // set, and valid stays high across back-to-back transfers
    task automatic send_console_item(input logic [MODE_W-1:0]      mode,
                                     input logic [CHAR_W-1:0]      ch,
                                     input logic [CELL_ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_char_code    <= ch;
        i_cell_address <= addr;
        // x on the stall counts as stalled
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // drop valid and let every outstanding result come back, so the block
    // is idle before the registers change
    task automatic drain_console();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_console_config(input logic [ATTR_W-1:0] attr,
                                      input logic [TOP_W-1:0]  top);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEXT_ATTRIBUTE;
        i_cfg_data  <= CFG_DATA_W'(attr);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCROLL_TOP;
        i_cfg_data  <= CFG_DATA_W'(top);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly console text: printable runs broken by newlines and backspaces,
    // occasional long lines that wrap (and scroll on the last row), plus
    // reads, clears, stray bytes and the unused mode; fields that a mode
    // ignores still carry random values
    task automatic run_console_traffic(input int newline_pct, input int target);
        int                     counted;
        int                     roll;
        int                     run_len;
        logic [MODE_W-1:0]      mode;
        logic [CHAR_W-1:0]      ch;
        logic [CELL_ADDR_W-1:0] addr;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 39) == 0) begin
                // a run of 60 to 100 printable characters, which can be longer than the screen is wide
                run_len = $urandom_range(60, 100);
                repeat (run_len) begin
                    send_console_item(MODE_PUT,
                                      CHAR_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)),
                                      CELL_ADDR_W'($urandom_range(0, 2047)));
                end
                counted += run_len;
            end else begin
                roll = $urandom_range(0, 99);
                ch   = CHAR_W'($urandom_range(0, 255));
                addr = CELL_ADDR_W'($urandom_range(0, 2047));
                if (roll < newline_pct) begin
                    mode = MODE_PUT;
                    ch   = CH_NEWLINE;
                end else if (roll < newline_pct + 5) begin
                    mode = MODE_PUT;
                    ch   = CH_BACKSPACE;
                end else if (roll < newline_pct + 9) begin
                    // any byte, control codes and high bytes included
                    mode = MODE_PUT;
                end else if (roll < newline_pct + 21) begin
                    mode = MODE_READ;
                    if ($urandom_range(0, 15) != 0)
                        addr = CELL_ADDR_W'($urandom_range(0, CELL_COUNT - 1));
                end else if (roll < newline_pct + 22) begin
                    mode = MODE_CLEAR;
                end else if (roll < newline_pct + 24) begin
                    mode = MODE_UNUSED;
                end else begin
                    mode = MODE_PUT;
                    ch   = CHAR_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
                end
                send_console_item(mode, ch, addr);
                // items the block merely ignores are not counted
                if (!(mode == MODE_UNUSED ||
                      (mode == MODE_PUT && ch != CH_NEWLINE && ch != CH_BACKSPACE &&
                       (ch < CH_FIRST_PRINT || ch > CH_LAST_PRINT))))
                    counted++;
            end
        end
    endtask

    // receiver: stall each result for a random hold, with quiet stretches
    initial begin
        int hold;
        bit out_quiet;
        out_quiet = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_quiet = !out_quiet;
            hold = out_quiet ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // sender, register writes and verdict
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_TEXT_ATTRIBUTE;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_PUT;
        i_char_code    <= '0;
        i_cell_address <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings; the input stalls through the clearing pass
        send_console_item(MODE_READ, 8'h00, 11'h000);
        send_console_item(MODE_READ, 8'hFF, CELL_ADDR_W'(CELL_COUNT - 1));
        // reads past the screen return zero
        send_console_item(MODE_READ, 8'h00, CELL_ADDR_W'(CELL_COUNT));
        send_console_item(MODE_READ, 8'h00, 11'h7FF);
        // printable bounds and a plain letter
        send_console_item(MODE_PUT, 8'h41, 11'h000);
        send_console_item(MODE_PUT, CH_LAST_PRINT, 11'h7FF);
        send_console_item(MODE_PUT, CH_FIRST_PRINT, 11'h000);
        // ignored bytes: delete, high byte, nul, last control code
        send_console_item(MODE_PUT, 8'h7F, 11'h000);
        send_console_item(MODE_PUT, 8'hFF, 11'h000);
        send_console_item(MODE_PUT, 8'h00, 11'h000);
        send_console_item(MODE_PUT, 8'h1F, 11'h000);
        // backspace blanks the space just written, then read it back
        send_console_item(MODE_PUT, CH_BACKSPACE, 11'h000);
        send_console_item(MODE_READ, 8'h00,
                          CELL_ADDR_W'(CURSOR_ROW_RESET * COLUMNS + 2));
        // backspace at column zero does nothing
        send_console_item(MODE_PUT, CH_NEWLINE, 11'h000);
        send_console_item(MODE_PUT, CH_BACKSPACE, 11'h000);
        send_console_item(MODE_UNUSED, 8'hAA, 11'h555);
        send_console_item(MODE_CLEAR, 8'h55, 11'h2AA);
        send_console_item(MODE_READ, 8'h00, CELL_ADDR_W'(int'(TOP_RESET) * COLUMNS));

        // scroll top past the screen acts as the last row; the cursor then
        // sits on a protected row and a newline only moves it down
        drain_console();
        set_console_config(8'hFF, 5'd31);
        send_console_item(MODE_PUT, CH_NEWLINE, 11'h000);
        send_console_item(MODE_CLEAR, 8'h00, 11'h000);
        send_console_item(MODE_PUT, 8'h5A, 11'h000);
        // newline on the last row scrolls a one-row region
        send_console_item(MODE_PUT, CH_NEWLINE, 11'h000);
        send_console_item(MODE_READ, 8'h00, CELL_ADDR_W'((ROWS - 1) * COLUMNS));

        // random phases over a spread of settings; full-screen scrolling is
        // slow, so the whole-screen region gets the fewest items
        drain_console();
        set_console_config(8'h00, 5'd0);
        run_console_traffic(12, 120);
        drain_console();
        set_console_config(8'hFF, 5'd24);
        run_console_traffic(2, 250);
        drain_console();
        set_console_config(8'h1E, 5'd31);
        run_console_traffic(3, 250);
        drain_console();
        set_console_config(ATTR_W'($urandom_range(0, 255)), TOP_W'(ROWS));
        run_console_traffic(10, 200);
        drain_console();
        set_console_config(ATTR_W'($urandom_range(0, 255)), 5'd18);
        run_console_traffic(1, 250);
        drain_console();
        set_console_config(ATTR_W'($urandom_range(0, 255)), TOP_W'($urandom_range(0, 31)));
        run_console_traffic(6, 200);
        drain_console();
        set_console_config(8'h80, 5'd23);
        run_console_traffic(2, 200);
        drain_console();
        set_console_config(8'h7F, TOP_RESET);
        run_console_traffic(8, 150);

        // wait out the last results, then a little longer for strays
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
